/* hdl/aes_pkg.sv */
// AES-128 package: types, S-box tables, GF(2^8) helpers, round counts.
`timescale 1ns / 1ps
package aes_pkg;

   localparam int NumRounds = 10;
   localparam logic [7:0] RedPoly = 8'h1B;
   localparam logic [0:0] CMD_ENCRYPT = 1'b0;
   localparam logic [0:0] CMD_DECRYPT = 1'b1;
   localparam logic [0:0] REG_KEY_HIGH = 1'b0;
   localparam logic [0:0] REG_KEY_LOW  = 1'b1;

   typedef logic [127:0] block_type;

   // Control info handed from cell to cell alongside the data.
   typedef struct packed {
      logic valid;
      logic decrypt;
   } stage_ctl_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? RedPoly : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h00;
      p = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) r = r ^ p;
         p = xtime(p);
      end
      gmul = r;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   // Byte i of a block sits in bits 127-8i downto 120-8i.
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      get_byte = b[127 - 8*i -: 8];
   endfunction

   function automatic logic [7:0] rcon_of(input int round);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 1; i < NumRounds; i++) begin
         if (i < round) r = xtime(r);
      end
      rcon_of = r;
   endfunction

   // One step of the key schedule: round key of round r from round r-1.
   function automatic block_type next_key(input block_type k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

endpackage

/* hdl/aes_stream_if.sv */
// Valid/ready channel interfaces for blocks and key-register writes.
`timescale 1ns / 1ps
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source (output valid, command, data_high, data_low, input ready);
   modport sink (input valid, command, data_high, data_low, output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/aes_key_cell.sv */
// Key schedule: expands the key into per-round keys (in encrypt and decrypt order).
`timescale 1ns / 1ps
module aes_key_cell
   import aes_pkg::*;
(
   input  logic      clock,
   input  logic      load,
   input  block_type key,
   output block_type rk_enc [NumRounds+1],
   output block_type rk_dec [NumRounds+1]
);
   // Expansion is a row of registered steps; the top level holds off input
   // until the last round key has settled after a key change.
   block_type rk_ff [NumRounds+1];
   block_type rk_in [NumRounds+1];

   always_comb begin
      rk_in[0] = key;
      for (int r = 1; r <= NumRounds; r++) begin
         rk_in[r] = next_key(rk_ff[r-1], rcon_of(r));
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r <= NumRounds; r++) begin
         if (load || r > 0) rk_ff[r] <= rk_in[r];
      end
   end

   always_comb begin
      for (int r = 0; r <= NumRounds; r++) begin
         rk_enc[r] = rk_ff[r];
         rk_dec[r] = rk_ff[NumRounds - r];
      end
   end
endmodule

/* hdl/aes_round_cell.sv */
// One round cell: sub/shift, mix and key add for either direction; the final cell skips the mix.
`timescale 1ns / 1ps
module aes_round_cell
   import aes_pkg::*;
#(
   parameter bit FinalRound = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  stage_ctl_type ctl_in,
   input  block_type     state_in,
   input  block_type     key_enc,
   input  block_type     key_dec,
   output stage_ctl_type ctl_out,
   output block_type     state_out
);
   stage_ctl_type ctl_ff;
   block_type     state_ff, state_in_c;
   block_type     ss, mixed, kadd;

   // Encrypt: SubBytes/ShiftRows, MixColumns, key. Decrypt (straight inverse):
   // InvShiftRows/InvSubBytes, key, InvMixColumns.
   always_comb begin
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (ctl_in.decrypt) begin
               ss[127 - 8*(r + 4*((c + r) % 4)) -: 8] =
                  INV_SBOX[get_byte(state_in, r + 4*c)];
            end else begin
               ss[127 - 8*(r + 4*c) -: 8] =
                  SBOX[get_byte(state_in, r + 4*((c + r) % 4))];
            end
         end
      end
      kadd = ss ^ (ctl_in.decrypt ? key_dec : key_enc);
      state_in_c = ctl_in.decrypt ? kadd : ss;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(state_in_c, 4*c);
         a1 = get_byte(state_in_c, 4*c+1);
         a2 = get_byte(state_in_c, 4*c+2);
         a3 = get_byte(state_in_c, 4*c+3);
         if (ctl_in.decrypt) begin
            mixed[127-8*(4*c)   -: 8] = gmul(a0,8'd14)^gmul(a1,8'd11)^gmul(a2,8'd13)^gmul(a3,8'd9);
            mixed[127-8*(4*c+1) -: 8] = gmul(a0,8'd9)^gmul(a1,8'd14)^gmul(a2,8'd11)^gmul(a3,8'd13);
            mixed[127-8*(4*c+2) -: 8] = gmul(a0,8'd13)^gmul(a1,8'd9)^gmul(a2,8'd14)^gmul(a3,8'd11);
            mixed[127-8*(4*c+3) -: 8] = gmul(a0,8'd11)^gmul(a1,8'd13)^gmul(a2,8'd9)^gmul(a3,8'd14);
         end else begin
            mixed[127-8*(4*c)   -: 8] = xtime(a0)^xtime(a1)^a1^a2^a3;
            mixed[127-8*(4*c+1) -: 8] = a0^xtime(a1)^xtime(a2)^a2^a3;
            mixed[127-8*(4*c+2) -: 8] = a0^a1^xtime(a2)^xtime(a3)^a3;
            mixed[127-8*(4*c+3) -: 8] = xtime(a0)^a0^a1^a2^xtime(a3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.decrypt <= ctl_in.decrypt;
         if (FinalRound) state_ff <= kadd;
         else if (ctl_in.decrypt) state_ff <= mixed;
         else state_ff <= mixed ^ key_enc;
      end
   end

   assign ctl_out   = ctl_ff;
   assign state_out = state_ff;
endmodule

/* hdl/aes128_block_cipher.sv */
// Top level: key registers, key schedule and the ten-cell round pipeline.
//
//  channel  dir  fields                         transfer when
//  req_     in   command, data_high, data_low   req.valid & req.ready
//  rsp_     out  result_high, result_low        rsp.valid & rsp.ready
//  csr_     in   index (0 key_high, 1 key_low)  csr.valid & csr.ready
//
// One block per cycle when not stalled; the pipeline is an input add-key
// stage plus ten round cells. The whole pipeline advances when the output
// slot is empty or taken; a stalled output freezes every cell. Reset
// clears the valid bits and the key registers. After a key write or
// reset, req.ready stays low until the key schedule has settled.
`timescale 1ns / 1ps
module aes128_block_cipher
   import aes_pkg::*;
(
   input logic clock,
   input logic reset,
   aes_req_if.sink   req,
   aes_rsp_if.source rsp,
   aes_csr_if.sink   csr
);
   logic [63:0]   key_high_ff, key_low_ff;
   logic [3:0]    settle_ff;
   logic          key_ready;
   logic          advance;
   stage_ctl_type ctl [NumRounds+1];
   block_type     st  [NumRounds+1];
   block_type     rk_enc [NumRounds+1];
   block_type     rk_dec [NumRounds+1];
   stage_ctl_type ctl0_ff;
   block_type     st0_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         settle_ff   <= 4'(NumRounds + 1);
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_KEY_HIGH: key_high_ff <= csr.data;
            REG_KEY_LOW:  key_low_ff  <= csr.data;
            default: ;
         endcase
         settle_ff <= 4'(NumRounds + 1);
      end else if (settle_ff != 4'd0) begin
         settle_ff <= settle_ff - 4'd1;
      end
   end
   assign key_ready = (settle_ff == 4'd0);

   aes_key_cell u_key (
      .clock  (clock),
      .load   (1'b1),
      .key    ({key_high_ff, key_low_ff}),
      .rk_enc (rk_enc),
      .rk_dec (rk_dec)
   );

   assign advance   = !ctl[NumRounds].valid || rsp.ready;
   assign req.ready = advance && key_ready;

   // Initial AddRoundKey cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl0_ff.valid <= req.valid && key_ready;
      end
      if (advance) begin
         ctl0_ff.decrypt <= (req.command == CMD_DECRYPT);
         st0_ff <= {req.data_high, req.data_low} ^
                   ((req.command == CMD_DECRYPT) ? rk_dec[0] : rk_enc[0]);
      end
   end
   assign ctl[0] = ctl0_ff;
   assign st[0]  = st0_ff;

   for (genvar g = 1; g <= NumRounds; g++) begin : g_round
      aes_round_cell #(.FinalRound(g == NumRounds)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_in    (ctl[g-1]),
         .state_in  (st[g-1]),
         .key_enc   (rk_enc[g]),
         .key_dec   (rk_dec[g]),
         .ctl_out   (ctl[g]),
         .state_out (st[g])
      );
   end

   assign rsp.valid       = ctl[NumRounds].valid;
   assign rsp.result_high = st[NumRounds][127:64];
   assign rsp.result_low  = st[NumRounds][63:0];
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the AES-128 encrypt/decrypt pipeline.
`timescale 1ns / 1ps
module testbench
   import aes_pkg::*;
();

   typedef struct {
      logic        command;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic        has_expected;
      logic [63:0] result_high;
      logic [63:0] result_low;
   } vector_type;

   logic clock;
   logic reset;

   aes_req_if req ();
   aes_rsp_if rsp ();
   aes_csr_if csr ();

   aes128_block_cipher i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   logic [63:0]  key_high_q;
   logic [63:0]  key_low_q;
   logic [127:0] block_fifo[$];
   int           error_count = 0;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   logic         holding;
   event         hold_go;
   vector_type   vectors[$];

   // GF(2^8) and S-box arithmetic, written out from first principles.
   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = gf_double(a);
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_inverse(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      int         e;
      r = 8'h01;
      p = x;
      e = 254;
      while (e != 0) begin
         if (e & 1) r = gf_mult(r, p);
         p = gf_mult(p, p);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   function automatic logic [7:0] fwd_sub(input logic [7:0] x);
      logic [7:0] b;
      b = gf_inverse(x);
      return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] rev_sub(input logic [7:0] s);
      return gf_inverse(rol8(s, 1) ^ rol8(s, 3) ^ rol8(s, 6) ^ 8'h05);
   endfunction

   // Byte j of the state is s[j]; column c holds bytes 4c..4c+3.
   function automatic logic [127:0] aes_transform(input logic decrypt,
         input logic [127:0] blk, input logic [63:0] kh, input logic [63:0] kl);
      logic [7:0]  w[44][4];
      logic [7:0]  rk[11][16];
      logic [7:0]  s[16];
      logic [7:0]  t[16];
      logic [7:0]  tw[4];
      logic [7:0]  col[4];
      logic [7:0]  rc;
      logic [7:0]  fw_coef[4];
      logic [7:0]  iv_coef[4];
      logic [127:0] key;
      logic [127:0] out;
      fw_coef = '{8'd2, 8'd3, 8'd1, 8'd1};
      iv_coef = '{8'd14, 8'd11, 8'd13, 8'd9};
      key = {kh, kl};
      rc = 8'h01;
      for (int i = 0; i < 16; i++) w[i / 4][i % 4] = key[127 - 8 * i -: 8];
      for (int i = 4; i < 44; i++) begin
         tw = w[i - 1];
         if (i % 4 == 0) begin
            tw = '{fwd_sub(w[i - 1][1]) ^ rc, fwd_sub(w[i - 1][2]),
                   fwd_sub(w[i - 1][3]), fwd_sub(w[i - 1][0])};
            rc = gf_double(rc);
         end
         for (int j = 0; j < 4; j++) w[i][j] = w[i - 4][j] ^ tw[j];
      end
      for (int r = 0; r <= 10; r++)
         for (int j = 0; j < 16; j++) rk[r][j] = w[4 * r + j / 4][j % 4];
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
      if (!decrypt) begin
         for (int j = 0; j < 16; j++) s[j] ^= rk[0][j];
         for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++) t[q + 4 * c] = fwd_sub(s[q + 4 * ((c + q) % 4)]);
            s = t;
            if (r < 10) begin
               for (int c = 0; c < 4; c++) begin
                  for (int q = 0; q < 4; q++) col[q] = s[4 * c + q];
                  for (int q = 0; q < 4; q++) begin
                     s[4 * c + q] = 8'h00;
                     for (int k = 0; k < 4; k++)
                        s[4 * c + q] ^= gf_mult(fw_coef[(k - q + 4) % 4], col[k]);
                  end
               end
            end
            for (int j = 0; j < 16; j++) s[j] ^= rk[r][j];
         end
      end else begin
         for (int j = 0; j < 16; j++) s[j] ^= rk[10][j];
         for (int r = 9; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++) t[q + 4 * ((c + q) % 4)] = rev_sub(s[q + 4 * c]);
            s = t;
            for (int j = 0; j < 16; j++) s[j] ^= rk[r][j];
            if (r > 0) begin
               for (int c = 0; c < 4; c++) begin
                  for (int q = 0; q < 4; q++) col[q] = s[4 * c + q];
                  for (int q = 0; q < 4; q++) begin
                     s[4 * c + q] = 8'h00;
                     for (int k = 0; k < 4; k++)
                        s[4 * c + q] ^= gf_mult(iv_coef[(k - q + 4) % 4], col[k]);
                  end
               end
            end
         end
      end
      for (int i = 0; i < 16; i++) out[127 - 8 * i -: 8] = s[i];
      return out;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   task automatic write_key(input logic [0:0] index, input logic [63:0] value);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (index == REG_KEY_HIGH) key_high_q = value;
      else key_low_q = value;
      @(negedge clock);
      csr.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Leaves req.valid high after the transfer so blocks can go back to back.
   task automatic send_block(input vector_type v);
      logic [127:0] want;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.command   <= v.command;
      req.data_high <= v.data_high;
      req.data_low  <= v.data_low;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      want = v.has_expected ? {v.result_high, v.result_low}
           : aes_transform(v.command, {v.data_high, v.data_low}, key_high_q, key_low_q);
      block_fifo.push_back(want);
      @(negedge clock);
   endtask

   // Quiet the pipeline before touching the key.
   task automatic drain_pipeline();
      req.valid <= 1'b0;
      while (block_fifo.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic random_phase(input int count, input int send_pct, input int recv_pct);
      vector_type v;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         v.command      = 1'($urandom_range(1));
         v.data_high    = {$urandom, $urandom};
         v.data_low     = {$urandom, $urandom};
         v.has_expected = 1'b0;
         send_block(v);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // Long receiver hold-off, counted here in cycles.
   initial begin
      holding = 1'b0;
      forever begin
         @(hold_go);
         holding = 1'b1;
         repeat (60) @(negedge clock);
         holding = 1'b0;
      end
   end

   // Receiver: random stalls plus the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (holding) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (block_fifo.size() == 0) begin
            report_mismatch("unexpected transfer, result_high", rsp.result_high, 64'h0);
         end else begin
            want = block_fifo.pop_front();
            if (rsp.result_high !== want[127:64])
               report_mismatch("result_high", rsp.result_high, want[127:64]);
            if (rsp.result_low !== want[63:0])
               report_mismatch("result_low", rsp.result_low, want[63:0]);
         end
      end
   end

   initial begin
      logic [63:0] keys_high[4];
      logic [63:0] keys_low[4];
      send_idle_pct = 0;
      recv_idle_pct = 0;
      key_high_q    = 64'h0;
      key_low_q     = 64'h0;
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.command   = CMD_ENCRYPT;
      req.data_high = '0;
      req.data_low  = '0;
      csr.valid     = 1'b0;
      csr.index     = REG_KEY_HIGH;
      csr.data      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (12) @(negedge clock);

      // Zero key after reset: known-answer vectors, then extremes.
      vectors.push_back('{CMD_ENCRYPT, 64'h0, 64'h0, 1'b1,
                          64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
      vectors.push_back('{CMD_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1,
                          64'h0, 64'h0});
      vectors.push_back('{CMD_ENCRYPT, '1, '1, 1'b0, 0, 0});
      vectors.push_back('{CMD_DECRYPT, '1, '1, 1'b0, 0, 0});
      vectors.push_back('{CMD_DECRYPT, 64'h0, 64'h0, 1'b0, 0, 0});
      vectors.push_back('{CMD_ENCRYPT, 64'h8000000000000000, 64'h1, 1'b0, 0, 0});
      foreach (vectors[i]) send_block(vectors[i]);
      drain_pipeline();

      // FIPS-197 appendix C.1 key.
      write_key(REG_KEY_HIGH, 64'h0001020304050607);
      write_key(REG_KEY_LOW,  64'h08090a0b0c0d0e0f);
      repeat (16) @(negedge clock);
      vectors.delete();
      vectors.push_back('{CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                          64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
      vectors.push_back('{CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
                          64'h0011223344556677, 64'h8899aabbccddeeff});
      vectors.push_back('{CMD_ENCRYPT, '1, 64'h0, 1'b0, 0, 0});
      vectors.push_back('{CMD_DECRYPT, 64'h0, '1, 1'b0, 0, 0});
      foreach (vectors[i]) send_block(vectors[i]);
      drain_pipeline();

      // All-ones key extreme.
      write_key(REG_KEY_HIGH, '1);
      write_key(REG_KEY_LOW, '1);
      repeat (16) @(negedge clock);
      vectors.delete();
      vectors.push_back('{CMD_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 0});
      vectors.push_back('{CMD_DECRYPT, '1, '1, 1'b0, 0, 0});
      vectors.push_back('{CMD_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 0, 0});
      foreach (vectors[i]) send_block(vectors[i]);
      drain_pipeline();

      keys_high = '{64'h0, '1, 64'h2b7e151628aed2a6, {$urandom, $urandom}};
      keys_low  = '{'1, 64'h0, 64'habf7158809cf4f3c, {$urandom, $urandom}};
      for (int p = 0; p < 4; p++) begin
         write_key(REG_KEY_HIGH, keys_high[p]);
         write_key(REG_KEY_LOW, keys_low[p]);
         repeat (16) @(negedge clock);
         if (p == 1) begin
            // Long receiver hold-off while the sender keeps pushing: pipeline fills.
            -> hold_go;
            random_phase(40, 0, 0);
         end
         random_phase(85, 11, 72);
         random_phase(85, 72, 11);
         random_phase(85, 0, 0);
         drain_pipeline();
      end

      while (block_fifo.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
